// ----- rtl/core/alpha_blend_pixel_store_core_macros.svh -----
// Assertion macros for the alpha blend pixel store core.
// Used by the checker file; depends on nothing else.
`ifndef ALPHA_BLEND_PIXEL_STORE_CORE_MACROS_SVH
`define ALPHA_BLEND_PIXEL_STORE_CORE_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ABPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion, also checked across reset
`define ABPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/abps_pkg.sv -----
// Shared types and constants for the alpha blend pixel store core.
// No dependencies; imported by every module of the block.
package abps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int COORD_W    = 16;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 32;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CH_W-1:0] ROUND_BIAS = 8'd127;
    localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_READ,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_X      = 3'd0,
        REG_CLIP_Y      = 3'd1,
        REG_CLIP_WIDTH  = 3'd2,
        REG_CLIP_HEIGHT = 3'd3,
        REG_PACK_MODE   = 3'd4,
        REG_RED_BITS    = 3'd5,
        REG_GREEN_BITS  = 3'd6,
        REG_BLUE_BITS   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [6:0] clip_x;
        logic [6:0] clip_y;
        logic [6:0] clip_width;
        logic [6:0] clip_height;
        logic       pack_mode;
        logic [3:0] red_bits;
        logic [3:0] green_bits;
        logic [3:0] blue_bits;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

endpackage

// ----- rtl/core/abps_cfg_regs.sv -----
// Configuration register bank: clip rectangle, pack mode, channel sizes.
// Depends on abps_pkg.
module abps_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [abps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output abps_pkg::t_cfg                  o_cfg
);
    import abps_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_x      <= 7'd0;
            r_cfg.clip_y      <= 7'd0;
            r_cfg.clip_width  <= 7'd64;
            r_cfg.clip_height <= 7'd64;
            r_cfg.pack_mode   <= 1'b1;
            r_cfg.red_bits    <= 4'd8;
            r_cfg.green_bits  <= 4'd8;
            r_cfg.blue_bits   <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CLIP_X:      r_cfg.clip_x      <= i_cfg_data;
                REG_CLIP_Y:      r_cfg.clip_y      <= i_cfg_data;
                REG_CLIP_WIDTH:  r_cfg.clip_width  <= i_cfg_data;
                REG_CLIP_HEIGHT: r_cfg.clip_height <= i_cfg_data;
                REG_PACK_MODE:   r_cfg.pack_mode   <= i_cfg_data[0];
                REG_RED_BITS:    r_cfg.red_bits    <= i_cfg_data[3:0];
                REG_GREEN_BITS:  r_cfg.green_bits  <= i_cfg_data[3:0];
                REG_BLUE_BITS:   r_cfg.blue_bits   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/abps_frame_mem.sv -----
// Frame store memory: one write port, one registered read port, and a
// zeroing sweep after reset. Depends on abps_pkg.
module abps_frame_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output logic [abps_pkg::PIX_W-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [abps_pkg::PIX_W-1:0]  i_wr_data,
    output logic                        o_clearing
);
    import abps_pkg::*;

    logic [PIX_W-1:0]  mem [DEPTH];
    logic [PIX_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

endmodule

// ----- rtl/core/abps_blend_unit.sv -----
// Arithmetic for one item: coverage-scaled alpha, source-over blend and
// scan-out repacking, in registered steps. Depends on abps_pkg.
module abps_blend_unit #(
    parameter int RED_SHIFT   = 16,
    parameter int GREEN_SHIFT = 8,
    parameter int BLUE_SHIFT  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_op,
    input  abps_pkg::t_color            i_color,
    input  logic [abps_pkg::CH_W-1:0]   i_coverage,
    input  abps_pkg::t_cfg              i_cfg,
    input  logic [abps_pkg::PIX_W-1:0]  i_dst,
    output logic [abps_pkg::PIX_W-1:0]  o_result
);
    import abps_pkg::*;

    localparam bit NATIVE_SHIFTS = (RED_SHIFT == 16) && (GREEN_SHIFT == 8) &&
                                   (BLUE_SHIFT == 0);

    function automatic logic [CH_W-1:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [CH_W-1:0] top_of(input logic [3:0] size);
        logic [8:0] t;
        t = (9'd1 << size[2:0]) - 9'd1;
        return t[7:0];
    endfunction

    logic [15:0]      r_prod_a;
    logic [CH_W-1:0]  r_alpha;
    logic [15:0]      r_sum [4];
    logic [15:0]      n_sum [4];
    logic [PIX_W-1:0] r_dst;

    logic [CH_W-1:0]  inv;
    logic [CH_W-1:0]  dst_ch [4];
    logic [CH_W-1:0]  src_ch [4];
    logic [3:0]       size_ch [4];
    logic [CH_W-1:0]  quo [4];
    logic [CH_W-1:0]  pk_ch [4];
    logic [PIX_W-1:0] src_word;
    logic [PIX_W-1:0] blend_word;
    logic [PIX_W-1:0] draw_word;
    logic [PIX_W-1:0] pack_word;
    logic [PIX_W-1:0] read_word;
    logic             native;

    assign inv = ALPHA_FULL - r_alpha;

    always_comb begin
        src_ch[0]  = r_alpha;
        src_ch[1]  = i_color.red;
        src_ch[2]  = i_color.green;
        src_ch[3]  = i_color.blue;
        size_ch[0] = 4'd0;
        size_ch[1] = i_cfg.red_bits;
        size_ch[2] = i_cfg.green_bits;
        size_ch[3] = i_cfg.blue_bits;
        for (int c = 0; c < 4; c++) begin
            dst_ch[c] = i_dst[PIX_W-1-CH_W*c -: CH_W];
            if (i_op == OP_READ) begin
                n_sum[c] = 16'(dst_ch[c]) * 16'(top_of(size_ch[c])) + 16'(ROUND_BIAS);
            end else if (c == 0) begin
                n_sum[c] = 16'(dst_ch[c]) * 16'(inv) + 16'(ROUND_BIAS);
            end else begin
                n_sum[c] = 16'(src_ch[c]) * 16'(r_alpha) +
                           16'(dst_ch[c]) * 16'(inv) + 16'(ROUND_BIAS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= 16'(i_coverage) * 16'(i_color.alpha) + 16'(ROUND_BIAS);
        r_alpha  <= div255(r_prod_a);
        r_dst    <= i_dst;
        for (int c = 0; c < 4; c++) begin
            r_sum[c] <= n_sum[c];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            quo[c] = div255(r_sum[c]);
            if (size_ch[c] == 4'd0) begin
                pk_ch[c] = '0;
            end else if (size_ch[c] >= 4'd8) begin
                pk_ch[c] = r_dst[PIX_W-1-CH_W*c -: CH_W];
            end else begin
                pk_ch[c] = quo[c];
            end
        end
        src_word   = {r_alpha, i_color.red, i_color.green, i_color.blue};
        blend_word = {r_alpha + quo[0], quo[1], quo[2], quo[3]};
        if (r_alpha == '0) begin
            draw_word = r_dst;
        end else if (r_alpha == ALPHA_FULL) begin
            draw_word = src_word;
        end else begin
            draw_word = blend_word;
        end
        native = !i_cfg.pack_mode ||
                 (NATIVE_SHIFTS && i_cfg.red_bits == 4'd8 &&
                  i_cfg.green_bits == 4'd8 && i_cfg.blue_bits == 4'd8);
        pack_word = (PIX_W'(pk_ch[1]) << RED_SHIFT) |
                    (PIX_W'(pk_ch[2]) << GREEN_SHIFT) |
                    (PIX_W'(pk_ch[3]) << BLUE_SHIFT);
        read_word = native ? r_dst : pack_word;
        o_result  = (i_op == OP_READ) ? read_word : draw_word;
    end

endmodule

// ----- rtl/core/alpha_blend_pixel_store_core.sv -----
// Alpha blend pixel store: top level with sequencer, item and output registers.
// Depends on abps_pkg, abps_cfg_regs, abps_frame_mem and abps_blend_unit.
//
// Usage:
//   s_axis carries draw and read words (tuser = opcode: 0 draw, 1 read).
//   A draw blends its color, alpha scaled by coverage, over the stored pixel
//   when the position is on screen and inside the clip rectangle; a read
//   returns the stored pixel in scan-out format. Each word gives exactly one
//   m_axis word: the pixel (tdata) and whether it was drawn or on screen (tuser).
//   The cfg channel writes one register per handshake and is always ready.
//   One word is in flight at a time: tready rises again only after the
//   address, memory read, multiply and divide steps around the single frame
//   memory port have run and the result is loaded into the output register.
//   After reset the frame memory is zeroed, one entry a cycle, over all
//   SCREEN_WIDTH * SCREEN_HEIGHT entries; s_axis_tready stays low until done.
//   When m_axis stalls, the result holds in the output register; one more
//   word is accepted and waits in its last step until the output drains.
module alpha_blend_pixel_store_core #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64,
    parameter int RED_SHIFT     = 16,
    parameter int GREEN_SHIFT   = 8,
    parameter int BLUE_SHIFT    = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_coord[15:0], y_coord[31:16], color_alpha[39:32], color_red[47:40],
    // color_green[55:48], color_blue[63:56], coverage[71:64]
    input  logic [71:0]                     s_axis_tdata,
    // opcode[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_word[31:0]
    output logic [abps_pkg::PIX_W-1:0]      m_axis_tdata,
    // drawn[0]
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [abps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import abps_pkg::*;

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] SCR_W = 17'(SCREEN_WIDTH);
    localparam logic [16:0] SCR_H = 17'(SCREEN_HEIGHT);

    function automatic logic in_clip(input logic [COORD_W-1:0] p,
                                     input logic [6:0] org,
                                     input logic [6:0] len,
                                     input logic [16:0] scr);
        logic [16:0] o;
        logic [16:0] e;
        o = 17'(org);
        e = o + 17'(len);
        if (o > scr) begin
            return 1'b0;
        end
        if (e > scr) begin
            e = scr;
        end
        return (17'(p) >= o) && (17'(p) < e);
    endfunction

    t_state r_state;
    t_state n_state;
    t_cfg   cfg;

    logic               r_op;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    t_color             r_color;
    logic [CH_W-1:0]    r_cov;

    logic [ADDR_W-1:0]  r_idx;
    logic               r_drawn;
    logic               n_on_screen;
    logic               n_in_clip;

    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_word;
    logic               r_out_drawn;

    logic               accept;
    logic               load_out;
    logic               wr_en;
    logic               clearing;
    logic [PIX_W-1:0]   rd_data;
    logic [PIX_W-1:0]   result;

    abps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    abps_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_idx),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_idx),
        .i_wr_data  (result),
        .o_clearing (clearing)
    );

    abps_blend_unit #(
        .RED_SHIFT   (RED_SHIFT),
        .GREEN_SHIFT (GREEN_SHIFT),
        .BLUE_SHIFT  (BLUE_SHIFT)
    ) u_blend (
        .i_clk      (i_clk),
        .i_op       (r_op),
        .i_color    (r_color),
        .i_coverage (r_cov),
        .i_cfg      (cfg),
        .i_dst      (rd_data),
        .o_result   (result)
    );

    assign accept = s_axis_tvalid && s_axis_tready;
    assign wr_en  = load_out && r_drawn && (r_op == OP_DRAW);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = r_out_drawn;

    always_comb begin
        n_on_screen = ({1'b0, r_x} < SCR_W) && ({1'b0, r_y} < SCR_H);
        n_in_clip   = in_clip(r_x, cfg.clip_x, cfg.clip_width, SCR_W) &&
                      in_clip(r_y, cfg.clip_y, cfg.clip_height, SCR_H);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x           <= s_axis_tdata[15:0];
            r_y           <= s_axis_tdata[31:16];
            r_color.alpha <= s_axis_tdata[39:32];
            r_color.red   <= s_axis_tdata[47:40];
            r_color.green <= s_axis_tdata[55:48];
            r_color.blue  <= s_axis_tdata[63:56];
            r_cov         <= s_axis_tdata[71:64];
            r_op          <= s_axis_tuser;
        end
        r_idx   <= ADDR_W'(32'(r_y) * 32'(SCREEN_WIDTH) + 32'(r_x));
        r_drawn <= n_on_screen && ((r_op == OP_READ) || n_in_clip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (!clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_READ;
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_word  <= r_drawn ? result : '0;
            r_out_drawn <= r_drawn;
        end
    end

endmodule

// ----- rtl/core/abps_checker.sv -----
// Port-level checks for alpha_blend_pixel_store_core, bound to the top level.
// Depends on abps_pkg and alpha_blend_pixel_store_core_macros.svh.
`include "alpha_blend_pixel_store_core_macros.svh"

module abps_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [abps_pkg::PIX_W-1:0]     m_axis_tdata,
    input logic                           m_axis_tuser
);
    import abps_pkg::*;

    `ABPS_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled output word changed")
    `ABPS_ASSERT(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken twice in a row")
    `ABPS_ASSERT(a_undrawn_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "undrawn word carries a pixel")
    `ABPS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready), "ports active right after reset")

endmodule

bind alpha_blend_pixel_store_core abps_checker u_abps_checker (.*);
